// ----- src/parameter_morph_interpolator_defines.svh -----
// Assertion macros for the parameter morph interpolator checker.
// Used by files that bind concurrent checks onto the block's ports.
`ifndef PARAMETER_MORPH_INTERPOLATOR_DEFINES_SVH
`define PARAMETER_MORPH_INTERPOLATOR_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define PMI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked while out of reset
`define PMI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/pmi_pkg.sv -----
// Shared types, constants and constant functions of the morph interpolator.
// No dependencies; imported by the front, back, top-level and checker modules.
package pmi_pkg;

  localparam int ONE_Q16   = 65536;
  localparam int HALF_Q16  = 32768;
  localparam int EPS_LSB   = 66;
  localparam int FRAC_BITS = 24;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 2;

  typedef enum logic [2:0] {
    MODE_LINEAR = 3'd0,
    MODE_GEO    = 3'd1,
    MODE_SWITCH = 3'd2,
    MODE_SLOT   = 3'd3,
    MODE_HOLD   = 3'd4
  } mode_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] a_value;
    logic signed [31:0] b_value;
    logic [7:0]         a_code;
    logic [7:0]         b_code;
    logic [16:0]        blend;
    logic [7:0]         a_source;
    logic [7:0]         a_target;
    logic [7:0]         b_source;
    logic [7:0]         b_target;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_out;
    logic [7:0]         code_out;
    logic [7:0]         source_out;
    logic [7:0]         target_out;
    logic               took_second;
  } out_item_t;

  // classified item: value = base + round(mul_x * mul_f / 65536)
  typedef struct packed {
    logic               geo;
    logic [16:0]        t;
    logic signed [32:0] mul_x;
    logic [17:0]        mul_f;
    logic signed [31:0] base;
    logic [31:0]        xa;
    logic [31:0]        xb;
    logic [7:0]         code;
    logic [7:0]         src;
    logic [7:0]         dst;
    logic               second;
  } cls_item_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] bitv;
    n = n_in;
    r = '0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 64'd0) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  // floor(2^(2^-k) * 2^30), built by repeated floor square roots
  function automatic logic [31:0] root_val(input int k);
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int j = 1; j <= k; j++) r = isqrt64(r << 30);
    return r[31:0];
  endfunction

endpackage

// ----- src/pmi_fifo.sv -----
// Small register queue used between front and back and at the result side.
// Depends on nothing; DEPTH must be a power of two.
module pmi_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + AW'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + AW'(1) : rp_r;
    cnt_nxt = cnt_r + CW'(do_push) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

endmodule

// ----- src/pmi_front.sv -----
// Front end: takes input items, saturates t and sorts each item by mode.
// Depends on pmi_pkg; writes classified items into the middle queue.
module pmi_front
  import pmi_pkg::*;
(
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  input  logic      q_full,
  output logic      q_push,
  output cls_item_t q_item
);
  logic [16:0]        t_s;
  logic               far;
  logic [17:0]        two_t;
  logic signed [32:0] a_ext, b_ext, diff;
  logic               match;

  assign in_full = q_full;
  assign q_push  = in_push && !q_full;

  always_comb begin
    t_s   = (in_item.blend > 17'(ONE_Q16)) ? 17'(ONE_Q16) : in_item.blend;
    far   = (t_s >= 17'(HALF_Q16));
    two_t = {t_s, 1'b0};
    a_ext = {in_item.a_value[31], in_item.a_value};
    b_ext = {in_item.b_value[31], in_item.b_value};
    diff  = b_ext - a_ext;
    match = (in_item.a_source == in_item.b_source) &&
            (in_item.a_target == in_item.b_target);

    q_item        = '0;
    q_item.t      = t_s;
    q_item.xa     = in_item.a_value[31] ? 32'(EPS_LSB)
                                        : 32'(in_item.a_value) + 32'(EPS_LSB);
    q_item.xb     = in_item.b_value[31] ? 32'(EPS_LSB)
                                        : 32'(in_item.b_value) + 32'(EPS_LSB);

    case (mode_t'(in_item.mode))
      MODE_LINEAR: begin
        q_item.mul_x = diff;
        q_item.mul_f = {1'b0, t_s};
        q_item.base  = in_item.a_value;
      end
      MODE_GEO: begin
        // endpoints fall back to the linear path, which returns a or b exactly
        q_item.mul_x = diff;
        q_item.mul_f = {1'b0, t_s};
        q_item.base  = in_item.a_value;
        q_item.geo   = (t_s != '0) && (t_s != 17'(ONE_Q16));
      end
      MODE_SWITCH: begin
        q_item.code   = far ? in_item.b_code : in_item.a_code;
        q_item.second = far;
      end
      MODE_SLOT: begin
        if (match) begin
          q_item.mul_x = diff;
          q_item.mul_f = {1'b0, t_s};
          q_item.base  = in_item.a_value;
          q_item.src   = in_item.a_source;
          q_item.dst   = in_item.a_target;
        end else if (!far) begin
          q_item.mul_x = a_ext;
          q_item.mul_f = 18'(ONE_Q16) - two_t;
          q_item.src   = in_item.a_source;
          q_item.dst   = in_item.a_target;
        end else begin
          q_item.mul_x  = b_ext;
          q_item.mul_f  = two_t - 18'(ONE_Q16);
          q_item.src    = in_item.b_source;
          q_item.dst    = in_item.b_target;
          q_item.second = 1'b1;
        end
      end
      default: begin
        q_item.base = in_item.a_value;
        q_item.code = in_item.a_code;
        q_item.src  = in_item.a_source;
        q_item.dst  = in_item.a_target;
      end
    endcase
  end

endmodule

// ----- src/pmi_back.sv -----
// Back end: stall-together pipeline with a multiply-add path, two log2 lanes,
// a log-domain lerp and an exp2 lane. Depends on pmi_pkg.
module pmi_back
  import pmi_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cls_item_t q_item,
  output logic      q_take,
  input  logic      o_full,
  output logic      o_push,
  output out_item_t o_item
);
  localparam int LOG_N = FRAC_BITS;
  localparam int IDX_LL = LOG_N + 1;
  localparam int IDX_LR = LOG_N + 2;
  localparam int LAST   = IDX_LR + FRAC_BITS + 1;
  localparam int DEPTH  = LAST + 1;

  typedef struct packed {
    logic               geo;
    logic [16:0]        t;
    logic signed [31:0] value;
    logic [7:0]         code;
    logic [7:0]         src;
    logic [7:0]         dst;
    logic               second;
  } side_t;

  side_t              side_r [DEPTH];
  side_t              s1_c, sl_c;
  logic [DEPTH-1:0]   vld_r;
  logic               adv;

  logic signed [51:0] prod_r;
  logic signed [31:0] base_r;
  logic signed [51:0] mul_c, rnd_c;

  logic [30:0]        ma_r [LOG_N+1];
  logic [30:0]        mb_r [LOG_N+1];
  logic [23:0]        fa_r [LOG_N+1];
  logic [23:0]        fb_r [LOG_N+1];
  logic [4:0]         pa_r [LOG_N+1];
  logic [4:0]         pb_r [LOG_N+1];

  logic [28:0]        la_r;
  logic signed [47:0] llp_r;
  logic [28:0]        la_c, lb_c;
  logic signed [29:0] ld_c;
  logic signed [47:0] llp_c, l_c;

  logic [31:0]        pr_r [FRAC_BITS+1];
  logic [23:0]        ef_r [FRAC_BITS+1];
  logic [4:0]         en_r [FRAC_BITS+1];

  logic [62:0]        sh_c;
  logic [32:0]        y_c;
  logic signed [33:0] r_c;
  logic signed [31:0] geo_c;
  logic [4:0]         pa_c, pb_c;
  logic [30:0]        ma_c, mb_c;

  function automatic logic [4:0] msb_idx(input logic [31:0] x);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 32; i++) if (x[i]) p = 5'(i);
    return p;
  endfunction

  function automatic logic [30:0] norm_m(input logic [31:0] x, input logic [4:0] p);
    logic [30:0] m;
    if (p == 5'd31) m = x[31:1];
    else m = 31'(x << (5'd30 - p));
    return m;
  endfunction

  assign adv    = !vld_r[LAST] || !o_full;
  assign q_take = adv && q_valid;
  assign o_push = vld_r[LAST] && !o_full;

  assign o_item.value_out   = side_r[LAST].value;
  assign o_item.code_out    = side_r[LAST].code;
  assign o_item.source_out  = side_r[LAST].src;
  assign o_item.target_out  = side_r[LAST].dst;
  assign o_item.took_second = side_r[LAST].second;

  always_comb begin
    mul_c = q_item.mul_x * $signed({1'b0, q_item.mul_f});
    rnd_c = (prod_r + 52'sd32768) >>> 16;
    pa_c  = msb_idx(q_item.xa);
    pb_c  = msb_idx(q_item.xb);
    ma_c  = norm_m(q_item.xa, pa_c);
    mb_c  = norm_m(q_item.xb, pb_c);

    la_c  = {pa_r[LOG_N], fa_r[LOG_N]};
    lb_c  = {pb_r[LOG_N], fb_r[LOG_N]};
    ld_c  = $signed({1'b0, lb_c}) - $signed({1'b0, la_c});
    llp_c = ld_c * $signed({1'b0, side_r[IDX_LL-1].t});
    l_c   = $signed({19'b0, la_r}) + ((llp_r + 48'sd32768) >>> 16);

    sh_c  = {31'b0, pr_r[FRAC_BITS]} << en_r[FRAC_BITS];
    y_c   = 33'((sh_c + 63'h2000_0000) >> 30);
    r_c   = $signed({1'b0, y_c}) - 34'sd66;
    if (r_c < 0) geo_c = '0;
    else if (r_c > 34'sd2147483647) geo_c = 32'sh7fff_ffff;
    else geo_c = r_c[31:0];

    s1_c       = side_r[0];
    s1_c.value = base_r + rnd_c[31:0];
    sl_c       = side_r[LAST-1];
    if (side_r[LAST-1].geo) sl_c.value = geo_c;
  end

  // control: valid bits advance together
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], q_valid};
    end
  end

  // side fields ride along; the value is filled in where it is computed
  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0].geo    <= q_item.geo;
      side_r[0].t      <= q_item.t;
      side_r[0].value  <= '0;
      side_r[0].code   <= q_item.code;
      side_r[0].src    <= q_item.src;
      side_r[0].dst    <= q_item.dst;
      side_r[0].second <= q_item.second;
      side_r[1]        <= s1_c;
      for (int i = 2; i < LAST; i++) side_r[i] <= side_r[i-1];
      side_r[LAST]     <= sl_c;
      prod_r   <= mul_c;
      base_r   <= q_item.base;
      ma_r[0]  <= ma_c;
      mb_r[0]  <= mb_c;
      pa_r[0]  <= pa_c;
      pb_r[0]  <= pb_c;
      fa_r[0]  <= '0;
      fb_r[0]  <= '0;
      llp_r    <= llp_c;
      la_r     <= la_c;
      pr_r[0]  <= 32'h4000_0000;
      ef_r[0]  <= (l_c < 0) ? 24'd0 : l_c[23:0];
      en_r[0]  <= (l_c < 0) ? 5'd0 : l_c[28:24];
    end
  end

  // log2 fraction: one squaring per stage on each lane
  for (genvar k = 0; k < LOG_N; k++) begin : g_log
    logic [61:0] sqa, sqb;
    logic [31:0] sa, sb;
    assign sqa = 62'(ma_r[k]) * 62'(ma_r[k]);
    assign sqb = 62'(mb_r[k]) * 62'(mb_r[k]);
    assign sa  = sqa[61:30];
    assign sb  = sqb[61:30];
    always_ff @(posedge clk) begin
      if (adv) begin
        ma_r[k+1] <= sa[31] ? sa[31:1] : sa[30:0];
        mb_r[k+1] <= sb[31] ? sb[31:1] : sb[30:0];
        fa_r[k+1] <= {fa_r[k][22:0], sa[31]};
        fb_r[k+1] <= {fb_r[k][22:0], sb[31]};
        pa_r[k+1] <= pa_r[k];
        pb_r[k+1] <= pb_r[k];
      end
    end
  end

  // exp2: multiply in one root per fraction bit, top bit first
  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_exp
    localparam logic [31:0] ROOT = root_val(k);
    logic [63:0] pm;
    assign pm = 64'(pr_r[k-1]) * 64'(ROOT);
    always_ff @(posedge clk) begin
      if (adv) begin
        pr_r[k] <= ef_r[k-1][FRAC_BITS-k] ? pm[61:30] : pr_r[k-1];
        ef_r[k] <= ef_r[k-1];
        en_r[k] <= en_r[k-1];
      end
    end
  end

endmodule

// ----- src/parameter_morph_interpolator.sv -----
// Parameter morph interpolator: takes one item per cycle while in_full is low and returns
// one result per item. The back end is a 52-stage pipeline whose depth is set by the
// geometric path: 24 squaring stages for log2 with two multipliers each (one per lane)
// and 24 root-multiply stages for exp2 with one multiplier each. All items take the same
// path, so results leave in order. Input and result sides are queues; the back pipeline
// stalls as a whole only when the result queue is full and a result waits.
module parameter_morph_interpolator
  import pmi_pkg::*;
#(
  parameter int MID_QDEPTH = MID_DEPTH,
  parameter int OUT_QDEPTH = OUT_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);
  logic      mq_push, mq_full, mq_empty, mq_pop;
  cls_item_t mq_wdata, mq_rdata;
  logic      oq_push, oq_full;
  out_item_t oq_wdata;

  pmi_front u_front (
    .in_push (in_push),
    .in_full (in_full),
    .in_item (in_item),
    .q_full  (mq_full),
    .q_push  (mq_push),
    .q_item  (mq_wdata)
  );

  pmi_fifo #(.WIDTH($bits(cls_item_t)), .DEPTH(MID_QDEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mq_push),
    .wdata (mq_wdata),
    .full  (mq_full),
    .pop   (mq_pop),
    .rdata (mq_rdata),
    .empty (mq_empty)
  );

  pmi_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (!mq_empty),
    .q_item  (mq_rdata),
    .q_take  (mq_pop),
    .o_full  (oq_full),
    .o_push  (oq_push),
    .o_item  (oq_wdata)
  );

  pmi_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(OUT_QDEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_wdata),
    .full  (oq_full),
    .pop   (out_pop),
    .rdata (out_item),
    .empty (out_empty)
  );

endmodule

// ----- src/pmi_checker.sv -----
// Port-level checks for the morph interpolator, bound onto the top level.
// Depends on pmi_pkg and parameter_morph_interpolator_defines.svh.
`include "parameter_morph_interpolator_defines.svh"

module pmi_checker
  import pmi_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_full,
  input logic      out_empty,
  input logic      out_pop,
  input out_item_t out_item
);

  // a waiting result holds until taken
  `PMI_ASSERT_NEXT(a_out_hold, !out_empty && !out_pop, !out_empty && $stable(out_item), "result changed while stalled")

  // a result from the second set is either a switched code or a slot with no code
  `PMI_ASSERT_NOW(a_second_shape, !out_empty && out_item.took_second, out_item.code_out == 8'd0 || (out_item.value_out == 32'sd0 && out_item.source_out == 8'd0 && out_item.target_out == 8'd0), "bad second-set result")

  // right after reset nothing waits and input is open
  `PMI_ASSERT_NOW(a_reset_state, $past(!rst_n), out_empty && !in_full, "queues not clear after reset")

endmodule

bind parameter_morph_interpolator pmi_checker u_pmi_checker (.*);
